### hw/rtl/pvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared constants, codes and controller/datapath command types for the
// pairwise vector similarity block.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned MAX_DIM = 1024;

  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [30:0]      EXP_NEG1_Q32 = 31'd1580030169;
  localparam logic [32:0]      ONE_Q32      = 33'h1_0000_0000;
  localparam logic [16:0]      ONE_Q16      = 17'h1_0000;
  localparam logic [3:0]       TAYLOR_TERMS = 4'd14;
  localparam logic [15:0]      EXP_INT_LIM  = 16'd12;

  localparam logic [MODE_W-1:0] MODE_DOT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXP = 2'd2;

  typedef enum logic [1:0] {
    RES_DOT,
    RES_ZERO,
    RES_COS,
    RES_EXP
  } res_sel_e;

  typedef enum logic [1:0] {
    SQ_A,
    SQ_B,
    SQ_D
  } sq_sel_e;

  typedef struct packed {
    logic     acc;
    logic     clr;
    logic     sq_start;
    sq_sel_e  sq_sel;
    logic     sq_step;
    logic     save_sa;
    logic     mul_den;
    logic     div_cos;
    logic     div_euc;
    logic     div_term;
    logic     div_step;
    logic [3:0] k;
    logic     save_x;
    logic     tacc;
    logic     clamp;
    logic     exp_step;
    logic     load_out;
    res_sel_e res_sel;
  } pvs_cmd_t;

  typedef struct packed {
    logic       norm_zero;
    logic       x_ge12;
    logic [3:0] n_low;
    logic       out_busy;
  } pvs_status_t;

endpackage

### hw/rtl/pvs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_stream_if
// Valid/ready channels: element pairs in, similarity results out.
// ----------------------------------------------------------------------------
interface pvs_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pvs_pkg::ELEM_W-1:0]  elem_a;
  logic signed [pvs_pkg::ELEM_W-1:0]  elem_b;
  logic                               last_elem;

  modport source (output valid, elem_a, elem_b, last_elem, input ready);
  modport sink   (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface pvs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pvs_pkg::ACC_W-1:0]  similarity;
  logic                              overflow;

  modport source (output valid, similarity, overflow, input ready);
  modport sink   (input valid, similarity, overflow, output ready);
endinterface

### hw/rtl/pvs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_ctrl
// Sequencer: accumulate phase, then square roots, divides and the exp series
// on the shared datapath units.
// ----------------------------------------------------------------------------
module pvs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  input  logic                        cfg_we_i,
  input  logic [pvs_pkg::MODE_W-1:0]  cfg_wdata_i,
  output pvs_pkg::pvs_cmd_t           cmd_o,
  input  pvs_pkg::pvs_status_t        status_i
);

  typedef enum logic [4:0] {
    S_ACC, S_DISPATCH, S_SQA, S_SAVEA, S_SQB, S_MUL, S_CDIV_INIT, S_CDIV,
    S_SQD, S_EDIV_INIT, S_EDIV, S_XSAVE, S_XCHK, S_TMUL, S_TDIV, S_TACC,
    S_CLAMP, S_EXPN, S_DONE
  } state_e;

  state_e                       state_q;
  logic [4:0]                   stp_q;
  logic [3:0]                   k_q;
  pvs_pkg::res_sel_e            res_sel_q;
  logic [pvs_pkg::MODE_W-1:0]   mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_ACC;
      stp_q     <= '0;
      k_q       <= '0;
      res_sel_q <= pvs_pkg::RES_DOT;
      mode_q    <= pvs_pkg::MODE_DOT;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      case (state_q)
        S_ACC: begin
          if (in_valid_i && in_last_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          stp_q <= 5'd31;
          case (mode_q)
            pvs_pkg::MODE_COS: begin
              if (status_i.norm_zero) begin
                res_sel_q <= pvs_pkg::RES_ZERO;
                state_q   <= S_DONE;
              end else begin
                state_q <= S_SQA;
              end
            end
            pvs_pkg::MODE_EXP: state_q <= S_SQD;
            default: begin
              res_sel_q <= pvs_pkg::RES_DOT;
              state_q   <= S_DONE;
            end
          endcase
        end
        S_SQA: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) state_q <= S_SAVEA;
        end
        S_SAVEA: begin
          stp_q   <= 5'd31;
          state_q <= S_SQB;
        end
        S_SQB: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_CDIV_INIT;
        S_CDIV_INIT: begin
          stp_q   <= 5'd31;
          state_q <= S_CDIV;
        end
        S_CDIV: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) begin
            res_sel_q <= pvs_pkg::RES_COS;
            state_q   <= S_DONE;
          end
        end
        S_SQD: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) state_q <= S_EDIV_INIT;
        end
        S_EDIV_INIT: begin
          stp_q   <= 5'd31;
          state_q <= S_EDIV;
        end
        S_EDIV: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) state_q <= S_XSAVE;
        end
        S_XSAVE: state_q <= S_XCHK;
        S_XCHK: begin
          k_q <= 4'd1;
          if (status_i.x_ge12) begin
            res_sel_q <= pvs_pkg::RES_ZERO;
            state_q   <= S_DONE;
          end else begin
            state_q <= S_TMUL;
          end
        end
        S_TMUL: begin
          stp_q   <= 5'd31;
          state_q <= S_TDIV;
        end
        S_TDIV: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == '0) state_q <= S_TACC;
        end
        S_TACC: begin
          k_q <= k_q + 4'd1;
          state_q <= (k_q == pvs_pkg::TAYLOR_TERMS) ? S_CLAMP : S_TMUL;
        end
        S_CLAMP: begin
          stp_q     <= {1'b0, status_i.n_low};
          res_sel_q <= pvs_pkg::RES_EXP;
          state_q   <= (status_i.n_low == '0) ? S_DONE : S_EXPN;
        end
        S_EXPN: begin
          stp_q <= stp_q - 5'd1;
          if (stp_q == 5'd1) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!status_i.out_busy) state_q <= S_ACC;
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_ACC);

  always_comb begin
    cmd_o         = '0;
    cmd_o.sq_sel  = pvs_pkg::SQ_A;
    cmd_o.res_sel = res_sel_q;
    cmd_o.k       = k_q;
    case (state_q)
      S_ACC: cmd_o.acc = in_valid_i;
      S_DISPATCH: begin
        if (mode_q == pvs_pkg::MODE_COS) begin
          cmd_o.sq_start = !status_i.norm_zero;
        end else if (mode_q == pvs_pkg::MODE_EXP) begin
          cmd_o.sq_start = 1'b1;
          cmd_o.sq_sel   = pvs_pkg::SQ_D;
        end
      end
      S_SQA, S_SQB, S_SQD: cmd_o.sq_step = 1'b1;
      S_SAVEA: begin
        cmd_o.save_sa  = 1'b1;
        cmd_o.sq_start = 1'b1;
        cmd_o.sq_sel   = pvs_pkg::SQ_B;
      end
      S_MUL:       cmd_o.mul_den  = 1'b1;
      S_CDIV_INIT: cmd_o.div_cos  = 1'b1;
      S_EDIV_INIT: cmd_o.div_euc  = 1'b1;
      S_CDIV, S_EDIV, S_TDIV: cmd_o.div_step = 1'b1;
      S_XSAVE:     cmd_o.save_x   = 1'b1;
      S_TMUL:      cmd_o.div_term = 1'b1;
      S_TACC:      cmd_o.tacc     = 1'b1;
      S_CLAMP:     cmd_o.clamp    = 1'b1;
      S_EXPN:      cmd_o.exp_step = 1'b1;
      S_DONE: begin
        cmd_o.load_out = !status_i.out_busy;
        cmd_o.clr      = !status_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/pvs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_datapath
// Saturating accumulators, bit-serial square root, restoring divider, exp
// series registers and the output register.
// ----------------------------------------------------------------------------
module pvs_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pvs_pkg::pvs_cmd_t                  cmd_i,
  output pvs_pkg::pvs_status_t               status_o,
  input  logic signed [pvs_pkg::ELEM_W-1:0]  elem_a_i,
  input  logic signed [pvs_pkg::ELEM_W-1:0]  elem_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pvs_pkg::ACC_W-1:0]   similarity_o,
  output logic                               overflow_o
);

  // accumulators
  logic signed [47:0] dot_q;
  logic [47:0]        na_q, nb_q, nd_q;
  logic [16:0]        cnt_q;
  logic               sat_q;

  // iteration units
  logic [63:0] sq_rad_q;
  logic [33:0] sq_rem_q;
  logic [31:0] sq_root_q;
  logic [31:0] sa_q;
  logic [63:0] den_q;
  logic [64:0] dv_rem_q;
  logic [31:0] dv_sh_q;
  logic [31:0] dv_q_q;
  logic [63:0] dv_den_q;
  logic        full_q;
  logic [15:0] xn_q;
  logic [15:0] f_q;
  logic [32:0] term_q;
  logic signed [35:0] sum_q;
  logic [32:0] ex_q;

  logic                      out_valid_q;
  logic signed [47:0]        sim_q;
  logic                      ovf_q;

  // accumulate terms
  logic signed [31:0] pab, paa, pbb;
  logic signed [16:0] dif;
  logic [16:0]        dm;
  logic [33:0]        dsq;
  logic signed [48:0] dot_ext;
  logic [47:0]        na_s, nb_s, nd_s;
  logic [16:0]        cnt_inc;
  logic               cnt_sat;

  always_comb begin
    pab     = elem_a_i * elem_b_i;
    paa     = elem_a_i * elem_a_i;
    pbb     = elem_b_i * elem_b_i;
    dif     = {elem_a_i[15], elem_a_i} - {elem_b_i[15], elem_b_i};
    dm      = dif[16] ? 17'(-dif) : 17'(dif);
    dsq     = dm * dm;
    dot_ext = {dot_q[47], dot_q} + {{17{pab[31]}}, pab};
    na_s    = na_q + {16'b0, paa};
    nb_s    = nb_q + {16'b0, pbb};
    nd_s    = nd_q + {14'b0, dsq};
    cnt_sat = (cnt_q == pvs_pkg::CNT_MAX);
    cnt_inc = cnt_sat ? cnt_q : cnt_q + 17'd1;
  end

  // square root step
  logic [35:0] sq_rsh, sq_trial;
  logic [47:0] sq_src;
  assign sq_rsh   = {sq_rem_q, sq_rad_q[63:62]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};

  always_comb begin
    case (cmd_i.sq_sel)
      pvs_pkg::SQ_A: sq_src = na_q;
      pvs_pkg::SQ_B: sq_src = nb_q;
      pvs_pkg::SQ_D: sq_src = nd_q;
      default:       sq_src = nd_q;
    endcase
  end

  // divide step
  logic [64:0] dv_rsh;
  logic [47:0] mag;
  logic [48:0] tprod;
  assign dv_rsh = {dv_rem_q[63:0], dv_sh_q[31]};
  assign mag    = dot_q[47] ? 48'(-dot_q) : 48'(dot_q);
  assign tprod  = term_q * f_q;

  logic [63:0] ex_prod;
  logic [64:0] ex_rnd;
  logic [33:0] ex_out;
  assign ex_prod = ex_q * pvs_pkg::EXP_NEG1_Q32;
  assign ex_rnd  = {1'b0, ex_prod} + 65'h8000_0000;
  assign ex_out  = {1'b0, ex_q} + 34'h8000;

  logic [16:0]        cos_mag;
  logic signed [47:0] res;
  always_comb begin
    if (full_q || dv_q_q > 32'(pvs_pkg::ONE_Q16)) cos_mag = pvs_pkg::ONE_Q16;
    else cos_mag = dv_q_q[16:0];
    case (cmd_i.res_sel)
      pvs_pkg::RES_DOT:  res = dot_q;
      pvs_pkg::RES_ZERO: res = '0;
      pvs_pkg::RES_COS:
        res = dot_q[47] ? -$signed({31'b0, cos_mag}) : $signed({31'b0, cos_mag});
      pvs_pkg::RES_EXP:  res = $signed({31'b0, ex_out[32:16]});
      default:           res = dot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      nd_q        <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        // clamp each sum at its limit and flag it; a count beyond MAX_DIM also sets the flag
        dot_q <= (dot_ext[48] != dot_ext[47]) ?
                 (dot_ext[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : dot_ext[47:0];
        na_q  <= na_s[47] ? {1'b0, {47{1'b1}}} : na_s;
        nb_q  <= nb_s[47] ? {1'b0, {47{1'b1}}} : nb_s;
        nd_q  <= nd_s[47] ? {1'b0, {47{1'b1}}} : nd_s;
        cnt_q <= cnt_inc;
        if ((dot_ext[48] != dot_ext[47]) || na_s[47] || nb_s[47] || nd_s[47] ||
            cnt_sat || (cnt_inc > 17'(pvs_pkg::MAX_DIM))) begin
          sat_q <= 1'b1;
        end
      end else if (cmd_i.clr) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
        nd_q  <= '0;
        cnt_q <= '0;
        sat_q <= 1'b0;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      sq_rad_q  <= {sq_src, 16'b0};
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sq_step) begin
      sq_rad_q <= {sq_rad_q[61:0], 2'b00};
      if (sq_rsh >= sq_trial) begin
        sq_rem_q  <= 34'(sq_rsh - sq_trial);
        sq_root_q <= {sq_root_q[30:0], 1'b1};
      end else begin
        sq_rem_q  <= sq_rsh[33:0];
        sq_root_q <= {sq_root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.save_sa) sa_q <= sq_root_q;
    if (cmd_i.mul_den) den_q <= sa_q * sq_root_q;

    if (cmd_i.div_cos) begin
      dv_rem_q <= {17'b0, mag};
      dv_sh_q  <= '0;
      dv_den_q <= den_q;
      full_q   <= ({16'b0, mag} >= den_q);
    end else if (cmd_i.div_euc) begin
      dv_rem_q <= '0;
      dv_sh_q  <= sq_root_q;
      dv_den_q <= (cnt_q == '0) ? 64'd1 : {47'b0, cnt_q};
    end else if (cmd_i.div_term) begin
      dv_rem_q <= '0;
      dv_sh_q  <= tprod[47:16];
      dv_den_q <= {60'b0, cmd_i.k};
    end else if (cmd_i.div_step) begin
      dv_sh_q <= {dv_sh_q[30:0], 1'b0};
      if (dv_rsh >= {1'b0, dv_den_q}) begin
        dv_rem_q <= dv_rsh - {1'b0, dv_den_q};
        dv_q_q   <= {dv_q_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= dv_rsh;
        dv_q_q   <= {dv_q_q[30:0], 1'b0};
      end
    end

    if (cmd_i.save_x) begin
      xn_q   <= dv_q_q[31:16];
      f_q    <= dv_q_q[15:0];
      term_q <= pvs_pkg::ONE_Q32;
      sum_q  <= $signed({3'b0, pvs_pkg::ONE_Q32});
    end else if (cmd_i.tacc) begin
      term_q <= {1'b0, dv_q_q};
      // odd terms subtract, even terms add
      if (cmd_i.k[0]) sum_q <= sum_q - $signed({4'b0, dv_q_q});
      else            sum_q <= sum_q + $signed({4'b0, dv_q_q});
    end

    if (cmd_i.clamp) begin
      if (sum_q[35]) ex_q <= '0;
      else if (sum_q > $signed({3'b0, pvs_pkg::ONE_Q32})) ex_q <= pvs_pkg::ONE_Q32;
      else ex_q <= sum_q[32:0];
    end else if (cmd_i.exp_step) begin
      ex_q <= ex_rnd[64:32];
    end

    if (cmd_i.load_out) begin
      sim_q <= res;
      ovf_q <= sat_q;
    end
  end

  assign status_o.norm_zero = (na_q == '0) || (nb_q == '0);
  assign status_o.x_ge12    = (xn_q >= pvs_pkg::EXP_INT_LIM);
  assign status_o.n_low     = xn_q[3:0];
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign overflow_o   = ovf_q;

endmodule

### hw/rtl/pairwise_vector_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_vector_similarity
// Streams two Q7.8 vectors as element pairs and reports one similarity value
// per vector pair in the metric set by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries elem_a/elem_b/last_elem; one pair is taken per cycle while
//   the block accumulates. The pair with last_elem set closes the vector pair.
//   out_o carries one result (similarity, overflow) per vector pair.
//   cfg_we_i/cfg_wdata_i write metric_mode; write it only while idle.
// Steps after the last pair, up to result valid:
//   dot product, and cosine with a zero norm: dispatch, then result load
//   cosine: two 32-step square roots, a multiply, a 32-step divide
//   exponential: 32-step root, 32-step divide, 14 series terms on the
//     shared divider, up to 11 exp(-1) steps; the series and exp(-1) steps
//     are skipped when the integer part of the scaled distance reaches 12
// Throughput: one pair per cycle inside a vector; no pairs are taken from
//   the last pair until the result is loaded into the output register.
// A stalled receiver holds the result; the next vector may stream in, but
// its result waits until the previous one is transferred.
// Reset clears the accumulators, the mode (dot product) and any result.
// ----------------------------------------------------------------------------
module pairwise_vector_similarity (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pvs_in_if.sink                      in_i,
  pvs_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [pvs_pkg::MODE_W-1:0]  cfg_wdata_i
);

  pvs_pkg::pvs_cmd_t    cmd;
  pvs_pkg::pvs_status_t status;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  pvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_elem),
    .in_ready_o  (in_ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pvs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .elem_a_i     (in_i.elem_a),
    .elem_b_i     (in_i.elem_b),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .similarity_o (out_o.similarity),
    .overflow_o   (out_o.overflow)
  );

endmodule

### hw/rtl/pvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_checker
// Port-level checks on the similarity block, bound to the top level.
// ----------------------------------------------------------------------------
module pvs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_last_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [pvs_pkg::ACC_W-1:0]  similarity_i,
  input logic                              overflow_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(similarity_i) &&
    $stable(overflow_i))
    else $error("result changed while stalled");

  // the last pair starts the compute phase, which takes no pairs
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("pair taken right after last pair");

  // a new result is loaded only from the compute phase
  a_rise_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared during accumulation");

endmodule

bind pairwise_vector_similarity pvs_checker u_pvs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last_elem),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .similarity_i (out_o.similarity),
  .overflow_i   (out_o.overflow)
);
